>>> rtl/ppt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_pkg: shared types and constants of the pocket perceptron trainer
// Holds action, status and register codes, the controller state type and the
// command and status bundles exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int NUM_WEIGHTS = 5;
    localparam int FEAT_W      = 16;
    localparam int WGT_W       = 24;
    localparam int ERR_W       = 11;
    localparam int CNT_W       = 6;
    localparam int PROD_W      = 40;
    localparam int SUM_W       = 43;
    localparam int SAMPLE_W    = 65;

    localparam logic [ERR_W-1:0] ERR_SAT = 11'd2047;
    localparam logic signed [WGT_W:0] BIAS_ONE = 25'sd4096;

    // Actions carried in the input tuser
    localparam logic [1:0] ACT_LOAD     = 2'd0;
    localparam logic [1:0] ACT_START    = 2'd1;
    localparam logic [1:0] ACT_UPDATE   = 2'd2;
    localparam logic [1:0] ACT_CLASSIFY = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CORRECT = 2'd1;
    localparam logic [1:0] ST_LIMIT   = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_SAMPLE_COUNT = 1'b0;
    localparam logic CFG_UPDATE_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_CLEAR,
        S_CHECK,
        S_READ,
        S_CAPTURE,
        S_DOT,
        S_WAIT_DOT,
        S_ADJUST,
        S_SCAN,
        S_DRAIN,
        S_POCKET,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic       wr_sample;
        logic       clear;
        logic       set_status;
        logic [1:0] status_code;
        logic       rd_index;
        logic       capture;
        logic       dot_go;
        logic       use_pocket;
        logic       keep_pred;
        logic       adjust;
        logic       scan_rd;
        logic       count_en;
        logic       pocket_upd;
        logic       out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       idx_over;
        logic       limit_hit;
        logic       dot_vld;
        logic       dot_match;
        logic       busy;
        logic       scan_last;
        logic       out_free;
    } dp_stat_t;

    // Clamp a 25-bit sum to the signed 24-bit weight range
    function automatic logic signed [WGT_W-1:0] sat_wgt(input logic signed [WGT_W:0] v);
        logic signed [WGT_W-1:0] r;
        if (v[WGT_W] != v[WGT_W-1])
        begin
            r = v[WGT_W] ? {1'b1, {(WGT_W-1){1'b0}}} : {1'b0, {(WGT_W-1){1'b1}}};
        end
        else
        begin
            r = v[WGT_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/ppt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ppt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/ppt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_ctrl: sequencer of the pocket perceptron trainer
// Steps each accepted action through the datapath by command bundles.
// ----------------------------------------------------------------------------
module ppt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    output logic               in_ready,
    input  ppt_pkg::dp_stat_t  stat,
    output ppt_pkg::ctl_cmd_t  cmd
);

    ppt_pkg::state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppt_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (stat.action)
                        ppt_pkg::ACT_LOAD:     state_next = ppt_pkg::S_LOAD;
                        ppt_pkg::ACT_START:    state_next = ppt_pkg::S_CLEAR;
                        ppt_pkg::ACT_UPDATE:   state_next = ppt_pkg::S_CHECK;
                        ppt_pkg::ACT_CLASSIFY: state_next = ppt_pkg::S_DOT;
                        default:               state_next = ppt_pkg::S_IDLE;
                    endcase
                end
            end
            ppt_pkg::S_LOAD:    state_next = ppt_pkg::S_FINISH;
            ppt_pkg::S_CLEAR:   state_next = ppt_pkg::S_FINISH;
            ppt_pkg::S_CHECK:
            begin
                priority if (stat.idx_over || stat.limit_hit)
                begin
                    state_next = ppt_pkg::S_FINISH;
                end
                else
                begin
                    state_next = ppt_pkg::S_READ;
                end
            end
            ppt_pkg::S_READ:    state_next = ppt_pkg::S_CAPTURE;
            ppt_pkg::S_CAPTURE: state_next = ppt_pkg::S_DOT;
            ppt_pkg::S_DOT:     state_next = ppt_pkg::S_WAIT_DOT;
            ppt_pkg::S_WAIT_DOT:
            begin
                if (stat.dot_vld)
                begin
                    if (stat.action == ppt_pkg::ACT_UPDATE && !stat.dot_match)
                    begin
                        state_next = ppt_pkg::S_ADJUST;
                    end
                    else
                    begin
                        state_next = ppt_pkg::S_FINISH;
                    end
                end
            end
            ppt_pkg::S_ADJUST:  state_next = ppt_pkg::S_SCAN;
            ppt_pkg::S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ppt_pkg::S_DRAIN;
                end
            end
            ppt_pkg::S_DRAIN:
            begin
                if (!stat.busy)
                begin
                    state_next = ppt_pkg::S_POCKET;
                end
            end
            ppt_pkg::S_POCKET:  state_next = ppt_pkg::S_FINISH;
            ppt_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ppt_pkg::S_IDLE;
                end
            end
            default:            state_next = ppt_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ppt_pkg::S_IDLE:    in_ready = 1'b1;
            ppt_pkg::S_LOAD:    cmd.wr_sample = 1'b1;
            ppt_pkg::S_CLEAR:   cmd.clear = 1'b1;
            ppt_pkg::S_CHECK:
            begin
                priority if (stat.idx_over)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ppt_pkg::ST_RANGE;
                end
                else if (stat.limit_hit)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ppt_pkg::ST_LIMIT;
                end
                else
                begin
                    cmd.rd_index = 1'b1;
                end
            end
            ppt_pkg::S_READ:    cmd.rd_index = 1'b0;
            ppt_pkg::S_CAPTURE: cmd.capture = 1'b1;
            ppt_pkg::S_DOT:
            begin
                cmd.dot_go     = 1'b1;
                cmd.use_pocket = (stat.action == ppt_pkg::ACT_CLASSIFY);
            end
            ppt_pkg::S_WAIT_DOT:
            begin
                cmd.keep_pred = stat.dot_vld;
                if (stat.dot_vld && stat.action == ppt_pkg::ACT_UPDATE && stat.dot_match)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ppt_pkg::ST_CORRECT;
                end
            end
            ppt_pkg::S_ADJUST:  cmd.adjust = 1'b1;
            ppt_pkg::S_SCAN:
            begin
                cmd.scan_rd  = 1'b1;
                cmd.count_en = 1'b1;
            end
            ppt_pkg::S_DRAIN:   cmd.count_en = 1'b1;
            ppt_pkg::S_POCKET:  cmd.pocket_upd = 1'b1;
            ppt_pkg::S_FINISH:  cmd.out_load = stat.out_free;
            default:            cmd = '0;
        endcase
    end

endmodule

>>> rtl/ppt_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_dpath: datapath of the pocket perceptron trainer
// Sample store, weights, pocket, two-stage dot product, error counter,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module ppt_dpath #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    // input transfer
    input  logic               in_fire,
    input  logic [1:0]         in_action,
    input  logic [9:0]         in_index,
    input  logic [63:0]        in_features,
    input  logic               in_label,
    // configuration
    input  logic               cfg_fire,
    input  logic               cfg_sel,
    input  logic [10:0]        cfg_value,
    // result
    input  logic               out_ready,
    output logic               out_valid,
    output logic [1:0]         out_status,
    output logic [143:0]       out_data,
    // control
    input  ppt_pkg::ctl_cmd_t  cmd,
    output ppt_pkg::dp_stat_t  stat
);

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int NW = ($clog2(MAX_SAMPLES + 1) > 11) ? $clog2(MAX_SAMPLES + 1) : 11;
    localparam int NWT = ppt_pkg::NUM_WEIGHTS;
    localparam int WW  = ppt_pkg::WGT_W;

    // Configuration
    logic [10:0]            count_cfg_reg;
    logic [ppt_pkg::CNT_W-1:0] limit_cfg_reg;
    // Held item
    logic [1:0]             action_reg;
    logic [9:0]             idx_reg;
    logic [63:0]            feat_reg;
    logic                   label_reg;
    // Training state
    logic signed [WW-1:0]   w_reg   [NWT];
    logic signed [WW-1:0]   pw_reg  [NWT];
    logic [ppt_pkg::ERR_W-1:0] perr_reg;
    logic                   pvalid_reg;
    logic [ppt_pkg::CNT_W-1:0] ucnt_reg;
    // Scan and dot product
    logic [AW-1:0]          scan_reg;
    logic                   rd_vld_reg;
    logic signed [ppt_pkg::PROD_W-1:0] prod_reg [4];
    logic signed [35:0]     bias_reg;
    logic                   a_vld_reg, a_lbl_reg;
    logic                   b_vld_reg, b_pred_reg, b_lbl_reg;
    logic [ppt_pkg::ERR_W-1:0] err_reg;
    // Result
    logic                   out_vld_reg;
    logic [1:0]             status_reg;
    logic                   pred_reg, match_reg;
    logic [1:0]             o_status_reg;
    logic [143:0]           o_data_reg;

    logic [NW-1:0]          n_use;
    logic [NW-1:0]          idx_ext;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [ppt_pkg::SAMPLE_W-1:0] ram_rdata;
    logic                   wr_en;
    logic                   a_go;
    logic [63:0]            a_feat;
    logic                   a_lbl;
    logic signed [WW-1:0]   a_w [NWT];
    logic signed [ppt_pkg::SUM_W-1:0] dot_sum;

    assign idx_ext = NW'(idx_reg);
    assign n_use   = (NW'(count_cfg_reg) < NW'(MAX_SAMPLES)) ? NW'(count_cfg_reg)
                                                             : NW'(MAX_SAMPLES);
    assign wr_en   = cmd.wr_sample && (idx_ext < NW'(MAX_SAMPLES));
    assign ram_re    = cmd.rd_index || cmd.scan_rd;
    assign ram_raddr = cmd.scan_rd ? scan_reg : idx_ext[AW-1:0];

    // Sample store: four features and the label
    ppt_ram #(
        .WIDTH (ppt_pkg::SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (idx_ext[AW-1:0]),
        .wdata ({label_reg, feat_reg}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_cfg_reg <= 11'd1024;
            limit_cfg_reg <= 6'd50;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_sel)
                ppt_pkg::CFG_SAMPLE_COUNT: count_cfg_reg <= cfg_value;
                ppt_pkg::CFG_UPDATE_LIMIT: limit_cfg_reg <= cfg_value[ppt_pkg::CNT_W-1:0];
                default:                   count_cfg_reg <= count_cfg_reg;
            endcase
        end
    end

    // Hold item; reload features from the store for an update
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            idx_reg   <= in_index;
            feat_reg  <= in_features;
            label_reg <= in_label;
        end
        else if (cmd.capture)
        begin
            feat_reg  <= ram_rdata[63:0];
            label_reg <= ram_rdata[64];
        end
    end

    // Dot product operand select
    assign a_go   = cmd.dot_go || (cmd.count_en && rd_vld_reg);
    assign a_feat = cmd.count_en ? ram_rdata[63:0] : feat_reg;
    assign a_lbl  = cmd.count_en ? ram_rdata[64] : label_reg;
    always_comb
    begin
        for (int i = 0; i < NWT; i++)
        begin
            a_w[i] = cmd.use_pocket ? pw_reg[i] : w_reg[i];
        end
    end

    // Stage one: products
    always_ff @(posedge clk)
    begin
        if (a_go)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i] <= a_w[i] * $signed(a_feat[16*i +: 16]);
            end
            bias_reg  <= {a_w[NWT-1], 12'b0};
            a_lbl_reg <= a_lbl;
        end
        if (a_vld_reg)
        begin
            b_pred_reg <= (dot_sum > 0);
            b_lbl_reg  <= a_lbl_reg;
        end
    end

    // Stage two: sum and sign
    assign dot_sum = ppt_pkg::SUM_W'(prod_reg[0]) + ppt_pkg::SUM_W'(prod_reg[1])
                   + ppt_pkg::SUM_W'(prod_reg[2]) + ppt_pkg::SUM_W'(prod_reg[3])
                   + ppt_pkg::SUM_W'(bias_reg);

    // Pipeline valids and scan address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            scan_reg   <= '0;
        end
        else
        begin
            rd_vld_reg <= ram_re;
            a_vld_reg  <= a_go;
            b_vld_reg  <= a_vld_reg;
            if (cmd.adjust)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    // Training state: weights, pocket, counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NWT; i++)
            begin
                w_reg[i]  <= '0;
                pw_reg[i] <= '0;
            end
            perr_reg   <= '0;
            pvalid_reg <= 1'b0;
            ucnt_reg   <= '0;
            err_reg    <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                err_reg <= '0;
            end
            else if (cmd.count_en && b_vld_reg && (b_pred_reg != b_lbl_reg)
                     && (err_reg != ppt_pkg::ERR_SAT))
            begin
                err_reg <= err_reg + 1'b1;
            end
            if (cmd.clear)
            begin
                for (int i = 0; i < NWT; i++)
                begin
                    w_reg[i]  <= '0;
                    pw_reg[i] <= '0;
                end
                perr_reg   <= '0;
                pvalid_reg <= 1'b0;
                ucnt_reg   <= '0;
            end
            if (cmd.adjust)
            begin
                for (int i = 0; i < NWT; i++)
                begin
                    w_reg[i] <= ppt_pkg::sat_wgt(label_reg
                        ? (WW+1)'(w_reg[i]) + ((i == NWT-1) ? ppt_pkg::BIAS_ONE
                              : (WW+1)'($signed(feat_reg[16*(i%4) +: 16])))
                        : (WW+1)'(w_reg[i]) - ((i == NWT-1) ? ppt_pkg::BIAS_ONE
                              : (WW+1)'($signed(feat_reg[16*(i%4) +: 16]))));
                end
                ucnt_reg <= ucnt_reg + 1'b1;
            end
            if (cmd.pocket_upd && (!pvalid_reg || err_reg < perr_reg))
            begin
                for (int i = 0; i < NWT; i++)
                begin
                    pw_reg[i] <= w_reg[i];
                end
                perr_reg   <= err_reg;
                pvalid_reg <= 1'b1;
            end
        end
    end

    // Result fields and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_reg  <= ppt_pkg::ACT_LOAD;
            status_reg  <= ppt_pkg::ST_OK;
            pred_reg    <= 1'b0;
            match_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                action_reg <= in_action;
                status_reg <= ppt_pkg::ST_OK;
                pred_reg   <= 1'b0;
                match_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.set_status)
                begin
                    status_reg <= cmd.status_code;
                end
                if (cmd.keep_pred)
                begin
                    pred_reg  <= b_pred_reg;
                    match_reg <= (b_pred_reg == b_lbl_reg);
                end
            end
            if (cmd.out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_status_reg <= status_reg;
            o_data_reg   <= {pw_reg[4], pw_reg[3], pw_reg[2], pw_reg[1], pw_reg[0],
                             perr_reg, err_reg, match_reg, pred_reg};
        end
    end

    assign out_valid  = out_vld_reg;
    assign out_status = o_status_reg;
    assign out_data   = o_data_reg;

    // Status to the controller; pass the incoming action through on a transfer
    assign stat.action    = in_fire ? in_action : action_reg;
    assign stat.idx_over  = (idx_ext >= n_use);
    assign stat.limit_hit = (ucnt_reg >= limit_cfg_reg);
    assign stat.dot_vld   = b_vld_reg;
    assign stat.dot_match = (b_pred_reg == b_lbl_reg);
    assign stat.busy      = rd_vld_reg || a_vld_reg || b_vld_reg;
    assign stat.scan_last = (NW'(scan_reg) == n_use - 1'b1);
    assign stat.out_free  = !out_vld_reg || out_ready;

endmodule

>>> rtl/pocket_perceptron_trainer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pocket_perceptron_trainer: fixed-point pocket perceptron trainer
// Each input transfer carries one action (load, start round, update,
// classify) in s_tuser and its operands in s_tdata; each action gives
// exactly one result transfer with status in m_tuser and the prediction,
// error counts and pocket weights in m_tdata.
// The cfg channel writes sample_count (index 0) and update_limit (index 1),
// always ready; write only while no action is in flight.
// One action is in flight at a time: s_tready is high only while idle.
// Load and start round take a single step before the result is loaded; a
// rejected update stops at the index and limit check, classify runs the
// two-stage dot product, and an update first reads its sample back through
// the registered store read. A weight update rescans the store one sample a
// cycle through that pipeline, then offers the weights to the pocket. The block
// is idle again when m_tvalid rises and can take the next transfer while it is high.
// Reset clears weights, pocket and the update counter and sets the config
// to 1024 samples and 50 updates; the store stays undefined until loaded.
// A stalled receiver holds the result in the output register; the next
// result waits until the previous one is handed over.
// ----------------------------------------------------------------------------
module pocket_perceptron_trainer #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // index[9:0], feature_a[25:10], feature_b[41:26], feature_c[57:42],
    // feature_d[73:58], label[74], zero pad[79:75]
    input  logic [79:0]  s_tdata,
    // action[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // prediction[0], matches_label[1], error_count[12:2], pocket_errors[23:13],
    // pocket_w0[47:24], pocket_w1[71:48], pocket_w2[95:72], pocket_w3[119:96],
    // pocket_w4[143:120]
    output logic [143:0] m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [10:0]  cfg_data
);

    ppt_pkg::ctl_cmd_t cmd;
    ppt_pkg::dp_stat_t stat;
    logic              in_fire;
    logic              in_ready;

    // Accept an input transfer
    assign in_fire   = s_tvalid && in_ready;
    assign s_tready  = in_ready;
    assign cfg_ready = 1'b1;

    ppt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ppt_dpath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .in_action   (s_tuser),
        .in_index    (s_tdata[9:0]),
        .in_features (s_tdata[73:10]),
        .in_label    (s_tdata[74]),
        .cfg_fire    (cfg_valid),
        .cfg_sel     (cfg_index),
        .cfg_value   (cfg_data),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (m_tuser),
        .out_data    (m_tdata),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
